>>> rtl/core/range_running_median_filter_defines.svh
// Assertion macros for the range running median filter.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef RANGE_RUNNING_MEDIAN_FILTER_DEFINES_SVH
`define RANGE_RUNNING_MEDIAN_FILTER_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge, off in reset.
`define RRMF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge, off in reset.
`define RRMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rrmf_pkg.sv
// Shared types and constants for the range running median filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rrmf_pkg;

    localparam int RANGE_W        = 16;
    localparam int DEF_WINDOW_LEN = 8;
    localparam int CFG_IDX_W      = 2;

    typedef logic [RANGE_W-1:0] t_range;

    localparam t_range RESET_MAX_VALID = 16'd8000;
    localparam t_range RESET_STALE     = 16'd150;
    localparam t_range SEED_FALLBACK   = 16'd150;
    localparam t_range TICK_MAX        = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_SEED   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_RSVD   = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE     = 2'd1;

    // Window write request from the sequencer.
    typedef struct packed {
        logic   seed_we;
        logic   samp_we;
        t_range data;
    } t_win_wr;

endpackage

>>> rtl/core/rrmf_window.sv
// Ring window store and write pointer for the range running median filter.
// Depends on rrmf_pkg.
`timescale 1ns / 1ps

module rrmf_window #(
    parameter int WINDOW_LEN = rrmf_pkg::DEF_WINDOW_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrmf_pkg::t_win_wr i_wr,
    output rrmf_pkg::t_range  o_window [WINDOW_LEN]
);
    import rrmf_pkg::*;

    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);

    t_range           r_window [WINDOW_LEN];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] n_wptr;

    always_comb begin
        n_wptr = r_wptr;
        if (i_wr.samp_we) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
        end else begin
            r_wptr <= n_wptr;
        end
    end

    // Seed fills every slot; a sample lands at the write pointer.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
            if (i_wr.seed_we || (i_wr.samp_we && (r_wptr == PTR_W'(i)))) begin
                r_window[i] <= i_wr.data;
            end
        end
    end

    assign o_window = r_window;

endmodule

>>> rtl/core/rrmf_rank.sv
// Rank unit: compares one candidate slot against the whole window and
// flags it when it sits at the median position. Depends on rrmf_pkg.
`timescale 1ns / 1ps

module rrmf_rank #(
    parameter int WINDOW_LEN = rrmf_pkg::DEF_WINDOW_LEN,
    parameter int PTR_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
    input  rrmf_pkg::t_range i_window [WINDOW_LEN],
    input  logic [PTR_W-1:0] i_cand,
    output rrmf_pkg::t_range o_cand_val,
    output logic             o_found
);
    import rrmf_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam logic [CNT_W-1:0] MED_IDX = CNT_W'(WINDOW_LEN / 2);

    t_range           w_cand;
    logic [CNT_W-1:0] w_lt_cnt;
    logic [CNT_W-1:0] w_le_cnt;

    assign w_cand = i_window[i_cand];

    always_comb begin
        w_lt_cnt = '0;
        w_le_cnt = '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            w_lt_cnt = w_lt_cnt + CNT_W'(i_window[i] <  w_cand);
            w_le_cnt = w_le_cnt + CNT_W'(i_window[i] <= w_cand);
        end
    end

    // The candidate covers sorted positions lt .. le-1.
    assign o_found    = (w_lt_cnt <= MED_IDX) && (w_le_cnt > MED_IDX);
    assign o_cand_val = w_cand;

endmodule

>>> rtl/core/range_running_median_filter.sv
// Top level of the range running median filter: sequencer, registers, output stage.
// Depends on rrmf_pkg, rrmf_window, rrmf_rank and the assertion macro header.
`timescale 1ns / 1ps
`include "range_running_median_filter_defines.svh"

// A seed, a tick, a rejected sample or an unused kind returns its result in
// the cycle after the input beat. An accepted sample is first written into
// the ring window; then a single rank unit tests one candidate slot per cycle
// against all slots until it finds the one at sorted position WINDOW_LEN/2.
// The block takes one item at a time; the next input beat is taken at the
// earliest in the cycle the previous result is taken. Configuration writes
// apply at once and should only come while idle.
module range_running_median_filter #(
    parameter int WINDOW_LEN = rrmf_pkg::DEF_WINDOW_LEN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rrmf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rrmf_pkg::RANGE_W-1:0]   i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_kind,
    input  logic [rrmf_pkg::RANGE_W-1:0]   i_range,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rrmf_pkg::RANGE_W-1:0]   o_distance,
    output logic                           o_fresh,
    output logic                           o_accepted
);
    import rrmf_pkg::*;

    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    t_state           r_state,    n_state;
    logic [PTR_W-1:0] r_cand,     n_cand;
    logic             r_started,  n_started;
    t_range           r_elapsed,  n_elapsed;
    t_range           r_median,   n_median;
    t_range           r_max_valid;
    t_range           r_stale;
    logic             r_out_valid, n_out_valid;
    t_range           r_out_dist,  n_out_dist;
    logic             r_out_fresh, n_out_fresh;
    logic             r_out_acc,   n_out_acc;

    t_win_wr w_wr;
    t_range  w_window [WINDOW_LEN];
    t_range  w_cand_val;
    logic    w_found;
    logic    w_in_acc;
    logic    w_out_take;
    logic    w_finish;
    logic    w_took;
    logic    w_fresh;
    t_range  w_seed;

    rrmf_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .o_window (w_window)
    );

    rrmf_rank #(
        .WINDOW_LEN (WINDOW_LEN),
        .PTR_W      (PTR_W)
    ) u_rank (
        .i_window   (w_window),
        .i_cand     (r_cand),
        .o_cand_val (w_cand_val),
        .o_found    (w_found)
    );

    assign o_stall    = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_take = r_out_valid && !i_stall;
    assign w_seed     = ((i_range == '0) || (i_range > r_max_valid)) ? SEED_FALLBACK
                                                                     : i_range;

    always_comb begin
        n_state      = r_state;
        n_cand       = r_cand;
        n_started    = r_started;
        n_elapsed    = r_elapsed;
        n_median     = r_median;
        w_wr.seed_we = 1'b0;
        w_wr.samp_we = 1'b0;
        w_wr.data    = (t_kind'(i_kind) == KIND_SEED) ? w_seed : i_range;
        w_finish     = 1'b0;
        w_took       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (t_kind'(i_kind))
                        KIND_SEED: begin
                            w_wr.seed_we = 1'b1;
                            n_median     = w_seed;
                            n_elapsed    = '0;
                            n_started    = 1'b1;
                            w_finish     = 1'b1;
                        end
                        KIND_SAMPLE: begin
                            if (r_started && (i_range < r_max_valid)) begin
                                w_wr.samp_we = 1'b1;
                                n_elapsed    = '0;
                                n_cand       = '0;
                                n_state      = S_SEARCH;
                            end else begin
                                w_finish = 1'b1;
                            end
                        end
                        KIND_TICK: begin
                            if (r_elapsed != TICK_MAX) begin
                                n_elapsed = r_elapsed + 1'b1;
                            end
                            w_finish = 1'b1;
                        end
                        KIND_RSVD: begin
                            w_finish = 1'b1;
                        end
                        default: begin
                            w_finish = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // Advance one candidate per cycle until it sits at the median rank.
                if (w_found) begin
                    n_median = w_cand_val;
                    n_state  = S_IDLE;
                    w_finish = 1'b1;
                    w_took   = 1'b1;
                end else begin
                    n_cand = r_cand + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_fresh = n_started && (n_elapsed <= r_stale);

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_dist  = r_out_dist;
        n_out_fresh = r_out_fresh;
        n_out_acc   = r_out_acc;
        if (w_finish) begin
            n_out_valid = 1'b1;
            n_out_dist  = w_fresh ? n_median : '0;
            n_out_fresh = w_fresh;
            n_out_acc   = w_took;
        end else if (w_out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cand      <= '0;
            r_started   <= 1'b0;
            r_elapsed   <= '0;
            r_median    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cand      <= n_cand;
            r_started   <= n_started;
            r_elapsed   <= n_elapsed;
            r_median    <= n_median;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_valid <= RESET_MAX_VALID;
            r_stale     <= RESET_STALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_VALID: r_max_valid <= i_cfg_data;
                CFG_STALE:     r_stale     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_dist  <= n_out_dist;
        r_out_fresh <= n_out_fresh;
        r_out_acc   <= n_out_acc;
    end

    assign o_valid    = r_out_valid;
    assign o_distance = r_out_dist;
    assign o_fresh    = r_out_fresh;
    assign o_accepted = r_out_acc;

    `RRMF_ASSERT_SAME(a_search_no_out, i_clk, i_rst_n, r_state == S_SEARCH, !r_out_valid, "result pending during median search")
    `RRMF_ASSERT_SAME(a_cand_range, i_clk, i_rst_n, r_state == S_SEARCH, r_cand < PTR_W'(WINDOW_LEN - 1) || r_cand == PTR_W'(WINDOW_LEN - 1), "median search ran past the window")
    `RRMF_ASSERT_NEXT(a_found_emits, i_clk, i_rst_n, r_state == S_SEARCH && w_found, r_out_valid && r_out_acc && r_state == S_IDLE, "median found without result")
    `RRMF_ASSERT_SAME(a_acc_fresh, i_clk, i_rst_n, r_out_valid && r_out_acc, r_out_fresh, "taken sample reported stale")

endmodule

>>> bench/range_running_median_filter_tb.sv
// Self-checking bench for range_running_median_filter: directed and random beats
// against an in-bench filter model. Depends on rrmf_pkg and the RTL of the block.
`timescale 1ns / 1ps

module range_running_median_filter_tb;
    import rrmf_pkg::*;

    localparam int WLEN = DEF_WINDOW_LEN;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 228;
    localparam int MAX_REPORTS = 100;
    // indexes past the register map; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    typedef struct {
        t_kind  kind;
        t_range rng;
    } t_beat;

    typedef struct {
        t_range distance;
        logic   fresh;
        logic   accepted;
    } t_reading;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    t_range               i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_kind = '0;
    t_range               i_range = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_range               o_distance;
    logic                 o_fresh;
    logic                 o_accepted;

    range_running_median_filter #(
        .WINDOW_LEN(WLEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_kind     (i_kind),
        .i_range    (i_range),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_distance (o_distance),
        .o_fresh    (o_fresh),
        .o_accepted (o_accepted)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Filter model state and its copy of the registers
    t_range win_m [WLEN];
    int     wr_idx = 0;
    t_range med_m = '0;
    t_range ticks_m = '0;
    bit     started_m = 1'b0;
    t_range lim_range = RESET_MAX_VALID;
    t_range lim_stale = RESET_STALE;

    t_beat    beats_to_send [$];
    t_reading readings_due [$];
    t_beat    cur_beat;
    t_reading oldest;
    int       mismatches = 0;
    int       gap_left = 0;
    int       burst_left = 0;
    int       stall_run = 0;
    int       stall_pct = 0;
    int       stall_epoch = 0;

    initial begin
        foreach (win_m[n]) win_m[n] = '0;
    end

    // Element at sorted position WLEN/2: the slot whose rank range covers it
    function automatic t_range window_median();
        t_range pick;
        int     lt;
        int     le;
        pick = '0;
        for (int a = 0; a < WLEN; a++) begin
            lt = 0;
            le = 0;
            for (int b = 0; b < WLEN; b++) begin
                if (win_m[b] < win_m[a]) lt++;
                if (win_m[b] <= win_m[a]) le++;
            end
            if (lt <= WLEN / 2 && WLEN / 2 < le) pick = win_m[a];
        end
        return pick;
    endfunction

    function automatic void track_item(input t_beat bt);
        t_reading r;
        t_range   seed;
        r.accepted = 1'b0;
        case (bt.kind)
            KIND_SEED: begin
                seed = (bt.rng == '0 || bt.rng > lim_range) ? SEED_FALLBACK : bt.rng;
                foreach (win_m[n]) win_m[n] = seed;
                med_m = seed;
                ticks_m = '0;
                started_m = 1'b1;
            end
            KIND_SAMPLE: begin
                if (started_m && bt.rng < lim_range) begin
                    win_m[wr_idx] = bt.rng;
                    wr_idx = (wr_idx + 1) % WLEN;
                    med_m = window_median();
                    ticks_m = '0;
                    r.accepted = 1'b1;
                end
            end
            KIND_TICK: begin
                if (ticks_m != TICK_MAX) ticks_m++;
            end
            default: ;
        endcase
        r.fresh = started_m && ticks_m <= lim_stale;
        r.distance = r.fresh ? med_m : '0;
        readings_due.push_back(r);
    endfunction

    function automatic void queue_beat(input t_kind k, input t_range rng);
        t_beat bt;
        bt.kind = k;
        bt.rng = rng;
        beats_to_send.push_back(bt);
    endfunction

    function automatic t_range pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (lim_range > 1 && roll < 80) return t_range'($urandom_range(0, int'(lim_range) - 1));
        if (roll < 86) return lim_range;
        if (roll < 90) return '0;
        if (roll < 94) return '1;
        return t_range'($urandom_range(0, 65535));
    endfunction

    function automatic t_range pick_seed();
        int roll;
        roll = $urandom_range(0, 99);
        if (lim_range != 0 && roll < 70) return t_range'($urandom_range(1, int'(lim_range)));
        if (roll < 78) return '0;
        if (roll < 84) return '1;
        if (roll < 90 && lim_range != '1) return lim_range + 1'b1;
        return t_range'($urandom_range(0, 65535));
    endfunction

    // Mostly seeded runs of samples and tick bursts; the rest is noise
    function automatic void queue_random_phase(input int n);
        int count;
        int roll;
        int run;
        int run_max;
        count = 0;
        run_max = (lim_stale < 40) ? int'(lim_stale) + 3 : 12;
        if ($urandom_range(0, 9) != 0) begin
            queue_beat(KIND_SEED, pick_seed());
            count++;
        end
        while (count < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 52) begin
                queue_beat(KIND_SAMPLE, pick_sample());
                count++;
            end else if (roll < 76) begin
                run = $urandom_range(1, run_max);
                repeat (run) queue_beat(KIND_TICK, t_range'($urandom_range(0, 65535)));
                count += run;
            end else if (roll < 86) begin
                queue_beat(KIND_SEED, pick_seed());
                count++;
            end else if (roll < 93) begin
                queue_beat(KIND_RSVD, t_range'($urandom_range(0, 65535)));
                count++;
            end else begin
                queue_beat(KIND_SAMPLE, t_range'($urandom_range(0, 65535)));
                count++;
            end
        end
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input t_range val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_VALID) lim_range = val;
        else if (idx == CFG_STALE) lim_stale = val;
    endtask

    task automatic wait_idle();
        while (beats_to_send.size() != 0 || i_valid || readings_due.size() != 0)
            @(posedge i_clk);
        repeat (WLEN + 4) @(posedge i_clk);
    endtask

    task automatic report(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endtask

    // Sender: bursts of beats separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) track_item(cur_beat);
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    cur_beat = beats_to_send.pop_front();
                    i_valid <= 1'b1;
                    i_kind <= cur_beat.kind;
                    i_range <= cur_beat.rng;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall density changes from one stretch to the next
    always @(posedge i_clk) begin
        if (stall_epoch == 0) begin
            stall_epoch = $urandom_range(100, 600);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 15;
                2: stall_pct = 40;
                default: stall_pct = 75;
            endcase
        end
        stall_epoch--;
        if (stall_run != 0) begin
            stall_run--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(0, 99) < stall_pct) stall_run = $urandom_range(1, 7);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (readings_due.size() == 0) begin
                report("unexpected beat, distance", -1, o_distance);
            end else begin
                oldest = readings_due.pop_front();
                if (o_distance !== oldest.distance)
                    report("distance", oldest.distance, o_distance);
                if (o_fresh !== oldest.fresh)
                    report("fresh", oldest.fresh, o_fresh);
                if (o_accepted !== oldest.accepted)
                    report("accepted", oldest.accepted, o_accepted);
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Before start, seed fallbacks and range limit edges at reset settings
        queue_beat(KIND_SAMPLE, 16'd100);
        queue_beat(KIND_TICK, 16'd0);
        queue_beat(KIND_RSVD, 16'hFFFF);
        queue_beat(KIND_SEED, 16'd0);
        queue_beat(KIND_SEED, 16'd8001);
        queue_beat(KIND_SEED, 16'd8000);
        queue_beat(KIND_SAMPLE, 16'd8000);
        queue_beat(KIND_SAMPLE, 16'd7999);
        queue_beat(KIND_SAMPLE, 16'd0);
        queue_beat(KIND_SAMPLE, 16'd1);
        queue_beat(KIND_TICK, 16'hFFFF);
        queue_beat(KIND_RSVD, 16'd0);
        queue_beat(KIND_SEED, 16'hFFFF);
        queue_beat(KIND_SAMPLE, 16'hFFFF);
        wait_idle();

        // Tight staleness, widest range, and writes to unmapped indexes
        cfg_write(CFG_STALE, 16'd2);
        cfg_write(CFG_MAX_VALID, 16'hFFFF);
        cfg_write(CFG_UNMAPPED_LO, 16'd5);
        cfg_write(CFG_UNMAPPED_HI, 16'd0);
        queue_beat(KIND_SEED, 16'd300);
        repeat (4) queue_beat(KIND_SAMPLE, 16'hFFFE);
        repeat (4) queue_beat(KIND_TICK, 16'd0);
        queue_beat(KIND_SAMPLE, 16'd5);
        queue_beat(KIND_SAMPLE, 16'hFFFF);
        wait_idle();

        // Open the staleness limit fully, reseed and tick a little
        cfg_write(CFG_STALE, 16'hFFFF);
        queue_beat(KIND_SEED, 16'd1000);
        repeat (3) queue_beat(KIND_TICK, 16'd0);
        queue_beat(KIND_SAMPLE, 16'd2000);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                2: cfg_write(CFG_MAX_VALID, 16'd0);
                4: cfg_write(CFG_MAX_VALID, 16'hFFFF);
                5: cfg_write(CFG_MAX_VALID, t_range'($urandom_range(1, 300)));
                default: cfg_write(CFG_MAX_VALID, t_range'($urandom_range(1, 65535)));
            endcase
            case (p)
                1: cfg_write(CFG_STALE, 16'd0);
                3: cfg_write(CFG_STALE, 16'hFFFF);
                6: cfg_write(CFG_STALE, t_range'($urandom_range(0, 200)));
                default: cfg_write(CFG_STALE, t_range'($urandom_range(0, 20)));
            endcase
            queue_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/rrmf_pkg.sv
rtl/core/rrmf_window.sv
rtl/core/rrmf_rank.sv
rtl/core/range_running_median_filter.sv
bench/range_running_median_filter_tb.sv
